// ===== hdl/qtd_pkg.sv =====
package qtd_pkg;

    // Item formats on the two channels.
    typedef struct packed {
        logic signed [31:0] sample;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  symbol_bits;
        logic [1:0]  status;
        logic [11:0] baud_length;
    } t_out_item;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_SYNC,
        ST_BAUD_MISMATCH,
        ST_AMBIGUOUS
    } t_status;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd2;

    localparam logic [31:0] PHASE_STEP_RST = 32'd89478485;
    localparam logic [30:0] THRESHOLD_RST  = 31'd10653;
    localparam logic [3:0]  TOLERANCE_RST  = 4'd2;

    localparam int MAX_BAUD_LEN = 4095;

    // Carrier constants: one eighth of a turn, pi/2 in Q32, peak amplitude.
    localparam logic [31:0] EIGHTH      = 32'h2000_0000;
    localparam logic [32:0] HALF_PI_Q32 = 33'h1_921F_B544;
    localparam logic [30:0] AMP_REF     = 31'h7F00_0000;
    localparam logic [32:0] SINE_ONE    = 33'h1_0000_0000;

    // Taylor series divisors, applied as exact reciprocal multiplies for
    // dividends below 2^34.
    localparam int SERIES_TERMS = 8;
    localparam int DIV_SHIFT [SERIES_TERMS] = '{43, 42, 42, 41, 41, 40, 39, 37};
    localparam logic [34:0] DIV_MUL [SERIES_TERMS] = '{
        35'(((64'd1 << 43) + 64'd271) / 64'd272),
        35'(((64'd1 << 42) + 64'd209) / 64'd210),
        35'(((64'd1 << 42) + 64'd155) / 64'd156),
        35'(((64'd1 << 41) + 64'd109) / 64'd110),
        35'(((64'd1 << 41) + 64'd71) / 64'd72),
        35'(((64'd1 << 40) + 64'd41) / 64'd42),
        35'(((64'd1 << 39) + 64'd19) / 64'd20),
        35'(((64'd1 << 37) + 64'd5) / 64'd6)
    };

    // Cycles from phase register to reference output of the sine pipeline.
    localparam int SIN_LAT = 2 * SERIES_TERMS + 5;

endpackage

// ===== hdl/qpsk_template_demodulator.sv =====
// Channel   | Signals                          | Carries
// ----------+----------------------------------+------------------------------
// input     | i_in_valid, o_in_ready, i_in_data | one audio sample and last flag
// output    | o_out_valid, i_out_ready, o_out_data | dibit, status, baud length
// config    | i_cfg_we, i_cfg_index, i_cfg_data | register writes, no handshake
//
// One sample is taken every cycle while the output is not stalled; a result is offered
// once its request has moved through the input register, the 21-stage carrier sine
// pipeline and the compare stage into the output register.
// Reset is synchronous and active low; it restores the registers and sync state.
// A result held in the output register and not taken stalls the whole pipeline,
// and the input then stops taking requests in the same cycle.
module qpsk_template_demodulator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  qtd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output qtd_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import qtd_pkg::*;

    typedef enum logic [2:0] {
        M_RUN0, M_RUN1, M_RUN2, M_RUN3, M_SKIP, M_DATA, M_DROP
    } t_mode;

    logic [31:0] r_phase_step;
    logic [30:0] r_thr;
    logic [3:0]  r_tol;

    logic        w_en, w_acc;
    logic [31:0] r_phase, r_ph_a, r_ph_b;
    logic        r_s0_valid;
    t_in_item    r_s0_item;
    logic        r_v  [SIN_LAT];
    t_in_item    r_it [SIN_LAT];
    logic signed [32:0] w_ref_a, w_ref_b;
    logic [3:0]  w_m;
    logic        r_c_valid, r_c_last;
    logic [3:0]  r_c_m, r_prev_m;

    t_mode       r_mode, n_mode;
    logic [11:0] r_len [4], n_len [4];
    logic [11:0] r_cnt [4], n_cnt [4];
    logic [11:0] r_baud, n_baud, r_pos, n_pos;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        w_emit, w_found, w_bad, w_dec, w_any, w_strict;
    t_out_item   w_res;
    logic [3:0]  w_hit, w_dm;
    logic [1:0]  w_fr, w_best;
    logic [13:0] w_sum, w_b;
    logic [15:0] w_b4, w_sum16;
    logic [11:0] w_bcnt [4], w_csum [4];
    logic [11:0] w_bpos, w_psum;

    function automatic logic fmatch(input logic signed [32:0] ref_v,
                                    input logic signed [31:0] smp,
                                    input logic [30:0] thr);
        logic signed [33:0] d;
        logic [33:0]        a;
        begin
            d = 34'(ref_v) - 34'(smp);
            a = d[33] ? 34'(-d) : 34'(d);
            return a <= {3'b000, thr};
        end
    endfunction

    function automatic logic [11:0] absdiff(input logic [11:0] a, input logic [11:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= PHASE_STEP_RST;
            r_thr        <= THRESHOLD_RST;
            r_tol        <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                CFG_THRESHOLD:  r_thr        <= i_cfg_data[30:0];
                CFG_TOLERANCE:  r_tol        <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register can take a result.
    assign w_en       = !r_out_valid || i_out_ready;
    assign w_acc      = i_in_valid && w_en;
    assign o_in_ready = w_en;

    // Input stage, sample phase and the valid shift line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_s0_valid <= 1'b0;
            r_c_valid  <= 1'b0;
            for (int k = 0; k < SIN_LAT; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in_valid;
            if (w_acc) r_phase <= i_in_data.last ? '0 : r_phase + r_phase_step;
            r_v[0] <= r_s0_valid;
            for (int k = 1; k < SIN_LAT; k++) r_v[k] <= r_v[k-1];
            r_c_valid <= r_v[SIN_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_item <= i_in_data;
            r_ph_a    <= r_phase + EIGHTH;
            r_ph_b    <= r_phase + 32'(3 * EIGHTH);
            r_it[0]   <= r_s0_item;
            for (int k = 1; k < SIN_LAT; k++) r_it[k] <= r_it[k-1];
            r_c_last  <= r_it[SIN_LAT-1].last;
            r_c_m     <= w_m;
        end
    end

    // Carriers at one and three eighths; the other two are their negatives.
    qtd_sine u_sine_a (.i_clk(i_clk), .i_en(w_en), .i_phase(r_ph_a), .o_ref(w_ref_a));
    qtd_sine u_sine_b (.i_clk(i_clk), .i_en(w_en), .i_phase(r_ph_b), .o_ref(w_ref_b));

    // Match flags in dibit order 00, 01, 10, 11.
    assign w_m[0] = fmatch(w_ref_b, r_it[SIN_LAT-1].sample, r_thr);
    assign w_m[1] = fmatch(w_ref_a, r_it[SIN_LAT-1].sample, r_thr);
    assign w_m[2] = fmatch(33'sd0 - w_ref_a, r_it[SIN_LAT-1].sample, r_thr);
    assign w_m[3] = fmatch(33'sd0 - w_ref_b, r_it[SIN_LAT-1].sample, r_thr);

    // Sync runs alternate between the 00 and 11 carriers.
    assign w_hit[0] = r_c_m[0];
    assign w_hit[1] = r_c_m[3];
    assign w_hit[2] = r_c_m[0];
    assign w_hit[3] = r_c_m[3] && (r_len[3] < r_len[0]);

    assign w_sum   = 14'(r_len[0]) + 14'(r_len[1]) + 14'(r_len[2]) + 14'(r_len[3]);
    assign w_b     = 14'((16'(w_sum) + 16'd2) >> 2);
    assign w_b4    = {w_b, 2'b00};
    assign w_sum16 = 16'(w_sum);
    assign w_bad   = (absdiff(r_len[0], r_len[1]) > 12'(r_tol))
                  || (absdiff(r_len[0], r_len[2]) > 12'(r_tol))
                  || (absdiff(r_len[1], r_len[3]) > 12'(r_tol))
                  || (absdiff(r_len[2], r_len[3]) > 12'(r_tol))
                  || (absdiff(r_len[0], r_len[3]) > 12'(r_tol));

    // Sync, decode and end-of-stream decisions for the item in the compare stage.
    always_comb begin
        n_mode = r_mode;
        n_len  = r_len;
        n_cnt  = r_cnt;
        n_baud = r_baud;
        n_pos  = r_pos;
        w_emit = 1'b0;
        w_res  = '0;
        w_dec  = 1'b0;
        w_bcnt = r_cnt;
        w_bpos = r_pos;
        w_dm   = r_c_m;
        w_found = 1'b0;
        w_fr    = 2'd0;
        w_any   = 1'b0;
        w_best  = 2'd0;
        w_strict = 1'b0;
        w_psum  = '0;
        for (int j = 0; j < 4; j++) w_csum[j] = '0;

        // Lowest run at or after the current one that the sample extends.
        for (int r = 3; r >= 0; r--) begin
            if ((r >= int'(r_mode)) && w_hit[r]) begin
                w_found = 1'b1;
                w_fr    = 2'(r);
            end
        end

        if (r_c_valid && w_en) begin
            unique case (r_mode)
                M_RUN0, M_RUN1, M_RUN2, M_RUN3: begin
                    if (w_found) begin
                        if (r_len[w_fr] >= 12'(MAX_BAUD_LEN)) begin
                            n_mode = M_DROP;
                            w_emit = 1'b1;
                            w_res.status = ST_NO_SYNC;
                        end else begin
                            n_len[w_fr] = r_len[w_fr] + 12'd1;
                            n_mode = t_mode'({1'b0, w_fr});
                        end
                    end else if (w_bad) begin
                        n_mode = M_DROP;
                        w_emit = 1'b1;
                        w_res.status      = ST_BAUD_MISMATCH;
                        w_res.baud_length = w_b[11:0];
                    end else if (w_b == 14'd0) begin
                        n_mode = M_DROP;
                        w_emit = 1'b1;
                        w_res.status = ST_NO_SYNC;
                    end else begin
                        n_baud = w_b[11:0];
                        n_pos  = '0;
                        n_mode = M_DATA;
                        for (int j = 0; j < 4; j++) w_bcnt[j] = '0;
                        w_bpos = '0;
                        if (w_b4 == w_sum16 + 16'd2) begin
                            n_mode = M_SKIP;
                        end else if (w_b4 == w_sum16 + 16'd1) begin
                            w_dec = 1'b0;
                        end else if (w_b4 + 16'd1 == w_sum16) begin
                            // Data began one sample back: decode that one first.
                            w_dec = 1'b1;
                            if (w_b == 14'd1) begin
                                w_dm = r_prev_m;
                            end else begin
                                for (int j = 0; j < 4; j++) w_bcnt[j] = 12'(r_prev_m[j]);
                                w_bpos = 12'd1;
                            end
                        end else begin
                            w_dec = 1'b1;
                        end
                    end
                end
                M_SKIP: n_mode = M_DATA;
                M_DATA: w_dec = 1'b1;
                default: ;
            endcase

            // Count matches over the baud and pick the strict maximum.
            if (w_dec) begin
                for (int j = 0; j < 4; j++) w_csum[j] = w_bcnt[j] + 12'(w_dm[j]);
                w_psum = w_bpos + 12'd1;
                if (w_psum >= n_baud) begin
                    for (int j = 0; j < 4; j++) begin
                        w_strict = 1'b1;
                        for (int o = 0; o < 4; o++) begin
                            if ((o != j) && (w_csum[o] >= w_csum[j])) w_strict = 1'b0;
                        end
                        if (w_strict) begin
                            w_any  = 1'b1;
                            w_best = 2'(j);
                        end
                    end
                    for (int j = 0; j < 4; j++) n_cnt[j] = '0;
                    n_pos  = '0;
                    w_emit = 1'b1;
                    w_res.baud_length = n_baud;
                    if (w_any) begin
                        w_res.symbol_bits = w_best;
                        w_res.status      = ST_OK;
                    end else begin
                        w_res.status = ST_AMBIGUOUS;
                        n_mode       = M_DROP;
                    end
                end else begin
                    n_cnt = w_csum;
                    n_pos = w_psum;
                end
            end

            // End of stream: report a missing sync, then start over.
            if (r_c_last) begin
                if (!w_emit && (n_mode <= M_RUN3)) begin
                    w_emit = 1'b1;
                    w_res  = '0;
                    w_res.status = ST_NO_SYNC;
                end
                n_mode = M_RUN0;
                for (int j = 0; j < 4; j++) begin
                    n_len[j] = '0;
                    n_cnt[j] = '0;
                end
                n_baud = '0;
                n_pos  = '0;
            end
        end
    end

    // Stream state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_RUN0;
            r_baud      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < 4; j++) begin
                r_len[j] <= '0;
                r_cnt[j] <= '0;
            end
        end else begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_cnt  <= n_cnt;
            r_baud <= n_baud;
            r_pos  <= n_pos;
            if (w_en) r_out_valid <= w_emit;
            if (w_emit) r_out <= w_res;
            if (r_c_valid && w_en) r_prev_m <= r_c_m;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/qtd_sine.sv =====
module qtd_sine (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_phase,
    output logic signed [32:0] o_ref
);
    import qtd_pkg::*;

    logic [1:0]  r_q1, r_q2, r_qs, r_qm;
    logic [33:0] r_x1, r_x2, r_sq2, r_s, r_mraw;
    logic [1:0]  r_qp  [SERIES_TERMS];
    logic [33:0] r_xp  [SERIES_TERMS];
    logic [33:0] r_sqp [SERIES_TERMS];
    logic [33:0] r_p   [SERIES_TERMS];
    logic [1:0]  r_qd  [SERIES_TERMS];
    logic [33:0] r_xd  [SERIES_TERMS];
    logic [33:0] r_sqd [SERIES_TERMS];
    logic [33:0] r_d   [SERIES_TERMS];
    logic signed [32:0] r_ref;

    logic [30:0] w_r;
    logic [63:0] w_xprod;
    logic [67:0] w_sqprod;
    logic [1:0]  w_pq   [SERIES_TERMS];
    logic [33:0] w_px   [SERIES_TERMS];
    logic [33:0] w_psq  [SERIES_TERMS];
    logic [32:0] w_t    [SERIES_TERMS];
    logic [66:0] w_pprod[SERIES_TERMS];
    logic [68:0] w_dprod[SERIES_TERMS];
    logic [33:0] w_dq   [SERIES_TERMS];
    logic [32:0] w_tlast;
    logic [66:0] w_sprod;
    logic [64:0] w_mprod;
    logic [33:0] w_mag;
    logic [31:0] w_magc;

    // Next series factor: one minus the scaled term, floored at zero.
    function automatic logic [32:0] next_t(input logic [33:0] d);
        logic [33:0] one_w;
        begin
            one_w = 34'(SINE_ONE);
            return (d > one_w) ? 33'd0 : 33'(one_w - d);
        end
    endfunction

    // Quarter-turn fraction, mirrored in odd quadrants, scaled to radians.
    assign w_r = i_phase[30] ? (31'h4000_0000 - {1'b0, i_phase[29:0]})
                             : {1'b0, i_phase[29:0]};
    assign w_xprod  = 64'(w_r) * 64'(HALF_PI_Q32);
    assign w_sqprod = 68'(r_x1) * 68'(r_x1);

    // Nested series: one multiply stage and one divide stage per term.
    always_comb begin
        for (int i = 0; i < SERIES_TERMS; i++) begin
            if (i == 0) begin
                w_pq[i]  = r_q2;
                w_px[i]  = r_x2;
                w_psq[i] = r_sq2;
                w_t[i]   = SINE_ONE;
            end else begin
                w_pq[i]  = r_qd[i-1];
                w_px[i]  = r_xd[i-1];
                w_psq[i] = r_sqd[i-1];
                w_t[i]   = next_t(r_d[i-1]);
            end
            w_pprod[i] = 67'(w_psq[i]) * 67'(w_t[i]);
            w_dprod[i] = 69'(r_p[i]) * 69'(DIV_MUL[i]);
            w_dq[i]    = 34'(w_dprod[i] >> DIV_SHIFT[i]);
        end
    end

    assign w_tlast = next_t(r_d[SERIES_TERMS-1]);
    assign w_sprod = 67'(r_xd[SERIES_TERMS-1]) * 67'(w_tlast);
    assign w_mprod = 65'(AMP_REF) * 65'(r_s);

    // Round to nearest and clamp to the peak amplitude.
    assign w_mag  = (r_mraw + 34'd1) >> 1;
    assign w_magc = (w_mag > 34'(AMP_REF)) ? 32'(AMP_REF) : w_mag[31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1  <= i_phase[31:30];
            r_x1  <= w_xprod[63:30];
            r_q2  <= r_q1;
            r_x2  <= r_x1;
            r_sq2 <= w_sqprod[65:32];
            for (int i = 0; i < SERIES_TERMS; i++) begin
                r_qp[i]  <= w_pq[i];
                r_xp[i]  <= w_px[i];
                r_sqp[i] <= w_psq[i];
                r_p[i]   <= w_pprod[i][65:32];
                r_qd[i]  <= r_qp[i];
                r_xd[i]  <= r_xp[i];
                r_sqd[i] <= r_sqp[i];
                r_d[i]   <= w_dq[i];
            end
            r_qs   <= r_qd[SERIES_TERMS-1];
            r_s    <= w_sprod[65:32];
            r_qm   <= r_qs;
            r_mraw <= w_mprod[64:31];
            r_ref  <= r_qm[1] ? (33'sd0 - $signed({1'b0, w_magc}))
                              : $signed({1'b0, w_magc});
        end
    end

    assign o_ref = r_ref;

endmodule

// ===== hdl/qtd_checker.sv =====
module qtd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input qtd_pkg::t_out_item o_out_data
);
    import qtd_pkg::*;

    // A held result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A held result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // A stalled output stops the input in the same cycle.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input request taken while the output is stalled");

    // Reset empties the output register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind qpsk_template_demodulator qtd_checker u_qtd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== bench/qpsk_template_demodulator_test.sv =====
`timescale 1ns / 100ps

module qpsk_template_demodulator_test;
    import qtd_pkg::*;

    localparam int M_SKIP = 4;
    localparam int M_DATA = 5;
    localparam int M_DROP = 6;
    localparam logic [63:0] UNIT_Q32 = 64'h1_0000_0000;
    localparam logic [63:0] HALF_PI = 64'h6487ED5110B4611A >> 30;
    localparam logic [63:0] PEAK = 64'h7F00_0000;

    typedef struct {
        logic [31:0] smp;
        bit          lst;
        bit          typed;
        t_out_item   want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = CFG_PHASE_STEP;
    logic [31:0] i_cfg_data = '0;

    // Settings as the demodulator currently holds them.
    logic [31:0] set_step = PHASE_STEP_RST;
    logic [30:0] set_thr = THRESHOLD_RST;
    logic [3:0]  set_tol = TOLERANCE_RST;

    // Mirror of the demodulator's stream state.
    int unsigned sync_mode;
    logic [31:0] carrier_phase;
    int unsigned run_len [4];
    int unsigned hit_cnt [4];
    int unsigned baud_q;
    int unsigned baud_pos;
    logic [31:0] prev_smp [2];

    t_out_item  symbols_due [$];
    int         n_errors = 0;
    int         n_sent = 0;

    qpsk_template_demodulator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Fixed-point carrier generation.
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    function automatic logic [63:0] series_div(input int i);
        case (i)
            0: return 64'd272;
            1: return 64'd210;
            2: return 64'd156;
            3: return 64'd110;
            4: return 64'd72;
            5: return 64'd42;
            6: return 64'd20;
            default: return 64'd6;
        endcase
    endfunction

    function automatic longint carrier(input logic [31:0] ph);
        logic [1:0]  q;
        logic [63:0] r, x, x2, t, d, s, mag;
        q = ph[31:30];
        r = {34'b0, ph[29:0]};
        if (q[0]) begin
            r = 64'h4000_0000 - r;
        end
        x = mul_shift(r, HALF_PI, 30);
        x2 = mul_shift(x, x, 32);
        t = UNIT_Q32;
        for (int i = 0; i < 8; i++) begin
            d = mul_shift(x2, t, 32) / series_div(i);
            t = (d > UNIT_Q32) ? 64'd0 : UNIT_Q32 - d;
        end
        s = mul_shift(x, t, 32);
        mag = (mul_shift(PEAK, s, 31) + 64'd1) >> 1;
        if (mag > PEAK) begin
            mag = PEAK;
        end
        return (q >= 2) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic int unsigned run_turn(input int r);
        return (r % 2 == 0) ? 3 : 7;
    endfunction

    function automatic int unsigned dibit_turn(input int j);
        case (j)
            0: return 3;
            1: return 1;
            2: return 5;
            default: return 7;
        endcase
    endfunction

    function automatic bit near_carrier(input logic [31:0] ph, input int unsigned k,
                                        input longint smp);
        longint d;
        logic [31:0] kph;
        kph = ph + k * EIGHTH;
        d = carrier(kph) - smp;
        if (d < 0) begin
            d = -d;
        end
        return d <= longint'(set_thr);
    endfunction

    function automatic int unsigned gap_of(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_out_item make_result(input int unsigned bits, input t_status st,
                                              input int unsigned b);
        t_out_item r;
        r.symbol_bits = bits[1:0];
        r.status = st;
        r.baud_length = b[11:0];
        return r;
    endfunction

    task automatic clear_stream();
        sync_mode = 0;
        carrier_phase = '0;
        baud_q = 0;
        baud_pos = 0;
        for (int j = 0; j < 4; j++) begin
            run_len[j] = 0;
            hit_cnt[j] = 0;
        end
    endtask

    // One sample of a data baud; a full baud yields its symbol.
    task automatic decode_sample(input logic [31:0] ph, input longint smp, output bit got,
                                 output t_out_item res);
        int unsigned best;
        bit strict;
        got = 0;
        best = 4;
        for (int j = 0; j < 4; j++) begin
            if (near_carrier(ph, dibit_turn(j), smp)) begin
                hit_cnt[j]++;
            end
        end
        baud_pos++;
        if (baud_pos < baud_q) begin
            return;
        end
        for (int j = 0; j < 4; j++) begin
            strict = 1;
            for (int o = 0; o < 4; o++) begin
                if (o != j && hit_cnt[o] >= hit_cnt[j]) begin
                    strict = 0;
                end
            end
            if (strict) begin
                best = j;
            end
        end
        baud_pos = 0;
        for (int j = 0; j < 4; j++) begin
            hit_cnt[j] = 0;
        end
        got = 1;
        if (best > 3) begin
            sync_mode = M_DROP;
            res = make_result(0, ST_AMBIGUOUS, baud_q);
        end else begin
            res = make_result(best, ST_OK, baud_q);
        end
    endtask

    // One sample during the preamble runs.
    task automatic sync_sample(input logic [31:0] ph, input longint smp, output bit got,
                               output t_out_item res);
        bit hit;
        int unsigned sum, b;
        got = 0;
        for (int r = sync_mode; r < 4; r++) begin
            hit = near_carrier(ph, run_turn(r), smp);
            if (r == 3 && !(run_len[3] < run_len[0])) begin
                hit = 0;
            end
            if (hit) begin
                if (run_len[r] >= MAX_BAUD_LEN) begin
                    sync_mode = M_DROP;
                    got = 1;
                    res = make_result(0, ST_NO_SYNC, 0);
                    return;
                end
                run_len[r]++;
                sync_mode = r;
                return;
            end
        end
        sum = run_len[0] + run_len[1] + run_len[2] + run_len[3];
        b = (sum + 2) / 4;
        if (gap_of(run_len[0], run_len[1]) > set_tol || gap_of(run_len[0], run_len[2]) > set_tol
                || gap_of(run_len[1], run_len[3]) > set_tol
                || gap_of(run_len[2], run_len[3]) > set_tol
                || gap_of(run_len[0], run_len[3]) > set_tol) begin
            sync_mode = M_DROP;
            got = 1;
            res = make_result(0, ST_BAUD_MISMATCH, b);
            return;
        end
        if (b == 0) begin
            sync_mode = M_DROP;
            got = 1;
            res = make_result(0, ST_NO_SYNC, 0);
            return;
        end
        baud_q = b;
        baud_pos = 0;
        sync_mode = M_DATA;
        if (4 * b == sum + 2) begin
            sync_mode = M_SKIP;
            return;
        end
        if (4 * b == sum + 1) begin
            return;
        end
        // Data began one sample early: decode the previous sample first.
        if (4 * b + 1 == sum) begin
            decode_sample(ph - set_step, longint'(signed'(prev_smp[1])), got, res);
            if (got) begin
                return;
            end
        end
        decode_sample(ph, smp, got, res);
    endtask

    task automatic predict_symbol(input t_in_item it, output bit got, output t_out_item res);
        logic [31:0] ph;
        longint smp;
        got = 0;
        smp = longint'(it.sample);
        ph = carrier_phase;
        prev_smp[1] = prev_smp[0];
        prev_smp[0] = it.sample;
        if (sync_mode < 4) begin
            sync_sample(ph, smp, got, res);
        end else if (sync_mode == M_SKIP) begin
            sync_mode = M_DATA;
        end else if (sync_mode == M_DATA) begin
            decode_sample(ph, smp, got, res);
        end
        carrier_phase = ph + set_step;
        if (it.last) begin
            if (!got && sync_mode < 4) begin
                got = 1;
                res = make_result(0, ST_NO_SYNC, 0);
            end
            clear_stream();
        end
    endtask

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Offer one request and wait until it is taken.
    task automatic send_sample(input logic [31:0] smp, input bit lst, input bit typed,
                               input t_out_item want);
        t_in_item it;
        t_out_item res;
        bit got;
        int g;
        it.sample = smp;
        it.last = lst;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
        predict_symbol(it, got, res);
        if (got) begin
            symbols_due.push_back(typed ? want : res);
        end
    endtask

    // Wait for the pipeline to drain, then write all three registers.
    task automatic write_settings(input logic [31:0] step, input logic [30:0] thr,
                                  input logic [3:0] tol);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (symbols_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_PHASE_STEP;
        i_cfg_data <= step;
        @(posedge i_clk);
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data <= {1'b0, thr};
        @(posedge i_clk);
        i_cfg_index <= CFG_TOLERANCE;
        i_cfg_data <= {28'b0, tol};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_step = step;
        set_thr = thr;
        set_tol = tol;
    endtask

    // A sample near the carrier at this stream position, within the threshold.
    function automatic logic [31:0] near_sample(input int idx, input int unsigned k);
        logic [31:0] ph;
        longint v, span;
        ph = idx * set_step + k * EIGHTH;
        span = (set_thr > 31'd1048576) ? 64'd1048576 : longint'(set_thr);
        case ($urandom_range(0, 5))
            0: v = carrier(ph) + span;
            1: v = carrier(ph) - span;
            default: v = carrier(ph) + longint'($urandom_range(0, 2 * span)) - span;
        endcase
        return v[31:0];
    endfunction

    // One stream: four preamble runs, data bauds, an optional partial baud.
    task automatic send_stream(input int l0, input int l1, input int l2, input int l3,
                               input int nsym, input int tail);
        logic [31:0] buffer [$];
        int lens [4];
        int idx, b, d;
        t_out_item none;
        none = '0;
        lens = '{l0, l1, l2, l3};
        idx = 0;
        for (int r = 0; r < 4; r++) begin
            for (int i = 0; i < lens[r]; i++) begin
                buffer.push_back(near_sample(idx, run_turn(r)));
                idx++;
            end
        end
        b = (l0 + l1 + l2 + l3 + 2) / 4;
        if (b < 1) begin
            b = 1;
        end
        for (int s = 0; s < nsym; s++) begin
            d = $urandom_range(0, 3);
            for (int i = 0; i < b; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    buffer.push_back($urandom);
                end else begin
                    buffer.push_back(near_sample(idx, dibit_turn(d)));
                end
                idx++;
            end
        end
        for (int i = 0; i < tail; i++) begin
            buffer.push_back(near_sample(idx, dibit_turn($urandom_range(0, 3))));
            idx++;
        end
        if (buffer.size() == 0) begin
            buffer.push_back($urandom);
        end
        foreach (buffer[i]) begin
            send_sample(buffer[i], i == buffer.size() - 1, 0, none);
        end
    endtask

    task automatic send_noise(input int n);
        t_out_item none;
        none = '0;
        for (int i = 0; i < n; i++) begin
            send_sample($urandom, i == n - 1, 0, none);
        end
    endtask

    task automatic random_stream();
        int unsigned kind;
        int l, l1, l2, l3;
        kind = $urandom_range(0, 99);
        l = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        if (set_thr > 31'd268435456 || kind < 10) begin
            send_noise($urandom_range(1, 6));
        end else if (kind < 70) begin
            l1 = l + $urandom_range(0, 2) - 1;
            l2 = l + $urandom_range(0, 2) - 1;
            l3 = l - $urandom_range(0, 1);
            if (l1 < 1) l1 = 1;
            if (l2 < 1) l2 = 1;
            if (l3 < 1) l3 = 1;
            if ($urandom_range(0, 1) == 0) begin
                l1 = l;
                l2 = l;
                l3 = l;
            end
            send_stream(l, l1, l2, l3, $urandom_range(1, 8), $urandom_range(0, 2));
        end else if (kind < 90) begin
            send_stream(l, l + $urandom_range(0, 8), $urandom_range(1, 12), l,
                        $urandom_range(0, 3), 0);
        end else begin
            send_stream(l, $urandom_range(0, l), 0, 0, 0, 0);
        end
    endtask

    // Receiver: random stalls plus one long hold-off that backs up the pipeline.
    initial begin
        int cycle_no;
        int left;
        bit level;
        cycle_no = 0;
        left = 0;
        level = 1;
        forever begin
            @(posedge i_clk);
            cycle_no++;
            if (cycle_no >= 3000 && cycle_no < 3400) begin
                i_out_ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    level = ($urandom_range(0, 99) < 65);
                    if (level) begin
                        left = $urandom_range(1, 40);
                    end else if ($urandom_range(0, 9) == 0) begin
                        left = $urandom_range(10, 40);
                    end else begin
                        left = $urandom_range(1, 3);
                    end
                end
                left--;
                i_out_ready <= level;
            end
        end
    end

    // Compare each taken result with the oldest expected symbol.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (symbols_due.size() == 0) begin
                $display("%0t: result with none expected: %p", $time, o_out_data);
                n_errors++;
            end else begin
                want = symbols_due.pop_front();
                if (o_out_data.symbol_bits !== want.symbol_bits) begin
                    $display("%0t: symbol_bits expected %0d actual %0d", $time,
                             want.symbol_bits, o_out_data.symbol_bits);
                    n_errors++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_out_data.status);
                    n_errors++;
                end
                if (o_out_data.baud_length !== want.baud_length) begin
                    $display("%0t: baud_length expected %0d actual %0d", $time,
                             want.baud_length, o_out_data.baud_length);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_out_item nosync;
        t_row rows [7];
        nosync = make_result(0, ST_NO_SYNC, 0);
        // A sample far from every carrier at once ends sync with no baud found.
        rows = '{
            '{32'h8000_0000, 1'b1, 1'b1, nosync},
            '{32'h7FFF_FFFF, 1'b1, 1'b1, nosync},
            '{32'h0000_0000, 1'b1, 1'b1, nosync},
            '{32'hFFFF_FFFF, 1'b0, 1'b1, nosync},
            '{32'h1234_5678, 1'b0, 1'b0, nosync},
            '{32'h8000_0001, 1'b1, 1'b0, nosync},
            '{32'h5A5A_5A5A, 1'b1, 1'b1, nosync}
        };
        clear_stream();
        prev_smp = '{32'h0, 32'h0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_sample(rows[i].smp, rows[i].lst, rows[i].typed, rows[i].want);
        end

        // Directed streams: clean sync, baud of one, each rounding case, mismatched runs.
        send_stream(3, 3, 3, 3, 3, 0);
        send_stream(1, 1, 1, 1, 4, 0);
        send_stream(4, 3, 3, 3, 2, 1);
        send_stream(3, 3, 3, 2, 2, 0);
        send_stream(3, 4, 4, 3, 2, 0);
        send_stream(2, 9, 2, 2, 1, 0);
        send_stream(3, 2, 0, 0, 0, 0);

        write_settings(32'h0, 31'd0, 4'd0);
        send_stream(2, 2, 2, 2, 3, 0);
        write_settings(32'hFFFF_FFFF, 31'h7FFF_FFFF, 4'd15);
        send_noise(3);
        write_settings(32'h2000_0000, 31'd50000, 4'd15);
        send_stream(3, 5, 1, 3, 3, 0);

        // Random part: new settings every few streams.
        while (n_sent < 1750) begin
            case ($urandom_range(0, 9))
                0: write_settings(PHASE_STEP_RST, THRESHOLD_RST, TOLERANCE_RST);
                1: write_settings($urandom, 31'h7FFF_FFFF - $urandom_range(0, 3),
                                  $urandom_range(0, 15));
                2: write_settings($urandom, 31'd0, $urandom_range(0, 15));
                default: write_settings($urandom, $urandom_range(0, 1 << 20),
                                        $urandom_range(0, 15));
            endcase
            repeat ($urandom_range(4, 10)) random_stream();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (symbols_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
